// ----- hdl/popcov_pkg.sv -----
package popcov_pkg;

  localparam int MAX_PAIRS_LOG2 = 15;

  localparam int VAL_W   = 24;
  localparam int COV_W   = 48;
  localparam int COUNT_W = 16;
  localparam int PSUM_W  = 64;
  localparam int LSUM_W  = 40;
  localparam int MUL_AW  = 25;
  localparam int MUL_PW  = MUL_AW + VAL_W;
  localparam int REM_W   = 16;
  localparam int SPLIT_W = 20;

  localparam logic [COUNT_W-1:0] PAIR_LIMIT = COUNT_W'(1) << MAX_PAIRS_LOG2;

  localparam logic signed [PSUM_W-1:0] COV_MAX = PSUM_W'((64'sd1 <<< (COV_W - 1)) - 64'sd1);
  localparam logic signed [PSUM_W-1:0] COV_MIN = -(PSUM_W'(64'sd1 <<< (COV_W - 1)));

  typedef struct packed {
    logic signed [VAL_W-1:0] x_value;
    logic signed [VAL_W-1:0] y_value;
    logic                    x_is_null;
    logic                    y_is_null;
    logic                    group_end;
  } in_item_t;

  typedef struct packed {
    logic signed [COV_W-1:0] covariance;
    logic                    result_is_null;
    logic [COUNT_W-1:0]      pairs_counted;
    logic                    count_overflow;
  } out_item_t;

endpackage

// ----- hdl/population_covariance_accumulator_unit.sv -----
// An item without group_end runs the states MUL and ACC, then returns to IDLE.
// A group_end item on a non-empty group then runs FIN, DIVY, MEAN, XLO, XHI, SUB, CABS,
// DIVC, SAT and OUT, using two 64-step restoring divisions on one shared divider plus
// one shared multiplier. An empty group goes from FIN straight to OUT for its null result.
// in_stall is high outside IDLE, so a new item is taken only after the last one is done.
// Reset (rst_n low, synchronous) clears all sums, the count, the overflow flag and out_valid.
module population_covariance_accumulator_unit
  import popcov_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL  = 4'd1;
  localparam logic [3:0] ST_ACC  = 4'd2;
  localparam logic [3:0] ST_FIN  = 4'd3;
  localparam logic [3:0] ST_DIVY = 4'd4;
  localparam logic [3:0] ST_MEAN = 4'd5;
  localparam logic [3:0] ST_XLO  = 4'd6;
  localparam logic [3:0] ST_XHI  = 4'd7;
  localparam logic [3:0] ST_SUB  = 4'd8;
  localparam logic [3:0] ST_CABS = 4'd9;
  localparam logic [3:0] ST_DIVC = 4'd10;
  localparam logic [3:0] ST_SAT  = 4'd11;
  localparam logic [3:0] ST_OUT  = 4'd12;

  logic [3:0]               state_r, state_nxt;
  logic signed [VAL_W-1:0]  x_r, x_nxt;
  logic signed [VAL_W-1:0]  y_r, y_nxt;
  logic                     skip_r, skip_nxt;
  logic                     last_r, last_nxt;
  logic signed [2*VAL_W-1:0] prod_r, prod_nxt;
  logic signed [PSUM_W-1:0] psum_r, psum_nxt;
  logic signed [LSUM_W-1:0] xsum_r, xsum_nxt;
  logic signed [LSUM_W-1:0] ysum_r, ysum_nxt;
  logic [COUNT_W-1:0]       count_r, count_nxt;
  logic                     ovf_r, ovf_nxt;
  logic signed [VAL_W-1:0]  mean_r, mean_nxt;
  logic signed [PSUM_W-1:0] cross_r, cross_nxt;
  logic [PSUM_W-1:0]        div_q_r, div_q_nxt;
  logic [REM_W-1:0]         div_rem_r, div_rem_nxt;
  logic [5:0]               div_cnt_r, div_cnt_nxt;
  logic                     div_neg_r, div_neg_nxt;
  logic signed [COV_W-1:0]  cov_r, cov_nxt;
  logic                     null_r, null_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  // Shared multiplier: x*y per pair, then the two halves of Sx*mean_y.
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [VAL_W-1:0]  mul_b;
  logic signed [MUL_PW-1:0] mul_p;

  always_comb begin
    case (state_r)
      ST_XLO: begin
        mul_a = $signed({{(MUL_AW - SPLIT_W){1'b0}}, xsum_r[SPLIT_W-1:0]});
        mul_b = mean_r;
      end
      ST_XHI: begin
        mul_a = $signed({{(MUL_AW - (LSUM_W - SPLIT_W)){xsum_r[LSUM_W-1]}},
                         xsum_r[LSUM_W-1:SPLIT_W]});
        mul_b = mean_r;
      end
      default: begin
        mul_a = MUL_AW'(x_r);
        mul_b = y_r;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Shared restoring divider step, divisor is the pair count.
  logic [REM_W:0]    rem_sh;
  logic              rem_ge;
  logic [REM_W:0]    rem_sub;
  logic [PSUM_W-1:0] q_signed;

  assign rem_sh  = {div_rem_r, div_q_r[PSUM_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, count_r};
  assign rem_sub = rem_sh - {1'b0, count_r};
  assign q_signed = div_neg_r ? (~div_q_r + PSUM_W'(1)) : div_q_r;

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    logic signed [PSUM_W-1:0] ysum_ext;
    logic signed [PSUM_W-1:0] cov_full;
    ysum_ext = PSUM_W'(ysum_r);
    cov_full = $signed(q_signed);

    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    skip_nxt      = skip_r;
    last_nxt      = last_r;
    prod_nxt      = prod_r;
    psum_nxt      = psum_r;
    xsum_nxt      = xsum_r;
    ysum_nxt      = ysum_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    mean_nxt      = mean_r;
    cross_nxt     = cross_r;
    div_q_nxt     = div_q_r;
    div_rem_nxt   = div_rem_r;
    div_cnt_nxt   = div_cnt_r;
    div_neg_nxt   = div_neg_r;
    cov_nxt       = cov_r;
    null_nxt      = null_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_data.x_value;
          y_nxt     = in_data.y_value;
          skip_nxt  = in_data.x_is_null || in_data.y_is_null;
          last_nxt  = in_data.group_end;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = mul_p[2*VAL_W-1:0];
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (!skip_r) begin
          if (count_r == PAIR_LIMIT) begin
            ovf_nxt = 1'b1;
          end else begin
            psum_nxt  = psum_r + PSUM_W'(prod_r);
            xsum_nxt  = xsum_r + LSUM_W'(x_r);
            ysum_nxt  = ysum_r + LSUM_W'(y_r);
            count_nxt = count_r + COUNT_W'(1);
          end
        end
        state_nxt = last_r ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        div_rem_nxt = '0;
        div_cnt_nxt = '1;
        div_neg_nxt = ysum_r[LSUM_W-1];
        div_q_nxt   = ysum_r[LSUM_W-1] ? -ysum_ext : ysum_ext;
        if (count_r == '0) begin
          cov_nxt   = '0;
          null_nxt  = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          null_nxt  = 1'b0;
          state_nxt = ST_DIVY;
        end
      end
      ST_DIVY, ST_DIVC: begin
        div_rem_nxt = rem_ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
        div_q_nxt   = {div_q_r[PSUM_W-2:0], rem_ge};
        div_cnt_nxt = div_cnt_r - 6'd1;
        if (div_cnt_r == '0) begin
          state_nxt = (state_r == ST_DIVY) ? ST_MEAN : ST_SAT;
        end
      end
      ST_MEAN: begin
        // The mean of 24-bit values always fits back into 24 bits.
        mean_nxt  = $signed(q_signed[VAL_W-1:0]);
        state_nxt = ST_XLO;
      end
      ST_XLO: begin
        cross_nxt = PSUM_W'(mul_p);
        state_nxt = ST_XHI;
      end
      ST_XHI: begin
        cross_nxt = cross_r + $signed({mul_p[PSUM_W-SPLIT_W-1:0], {SPLIT_W{1'b0}}});
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        cross_nxt = psum_r - cross_r;
        state_nxt = ST_CABS;
      end
      ST_CABS: begin
        div_rem_nxt = '0;
        div_cnt_nxt = '1;
        div_neg_nxt = cross_r[PSUM_W-1];
        div_q_nxt   = cross_r[PSUM_W-1] ? -cross_r : cross_r;
        state_nxt   = ST_DIVC;
      end
      ST_SAT: begin
        if (cov_full > COV_MAX) begin
          cov_nxt = COV_MAX[COV_W-1:0];
        end else if (cov_full < COV_MIN) begin
          cov_nxt = COV_MIN[COV_W-1:0];
        end else begin
          cov_nxt = cov_full[COV_W-1:0];
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.covariance     = cov_r;
          out_data_nxt.result_is_null = null_r;
          out_data_nxt.pairs_counted  = count_r;
          out_data_nxt.count_overflow = ovf_r;
          psum_nxt                    = '0;
          xsum_nxt                    = '0;
          ysum_nxt                    = '0;
          count_nxt                   = '0;
          ovf_nxt                     = 1'b0;
          state_nxt                   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      psum_r      <= '0;
      xsum_r      <= '0;
      ysum_r      <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      psum_r      <= psum_nxt;
      xsum_r      <= xsum_nxt;
      ysum_r      <= ysum_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    skip_r     <= skip_nxt;
    last_r     <= last_nxt;
    prod_r     <= prod_nxt;
    mean_r     <= mean_nxt;
    cross_r    <= cross_nxt;
    div_q_r    <= div_q_nxt;
    div_rem_r  <= div_rem_nxt;
    div_cnt_r  <= div_cnt_nxt;
    div_neg_r  <= div_neg_nxt;
    cov_r      <= cov_nxt;
    null_r     <= null_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= PAIR_LIMIT)
    else $error("pair count exceeded its limit");

  a_null_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_is_null |->
      out_data.pairs_counted == '0 && out_data.covariance == '0)
    else $error("null result carries a count or a value");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVY || state_r == ST_DIVC) |->
      {1'b0, div_rem_r} < {1'b0, count_r})
    else $error("divider remainder not below the pair count");

  a_end_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_OUT)
    else $error("result appeared outside the output step");
`endif

endmodule
